// ===== sv/skcc_pkg.sv =====
`timescale 1ns / 1ps

package skcc_pkg;

  localparam int LEVEL_BITS  = 24;
  localparam int FRAC_BITS   = 20;
  localparam int P_W         = $clog2(LEVEL_BITS);
  localparam int E_W         = 6;
  localparam int DB_W        = 17;
  localparam int Y_W         = 18;
  localparam int THR_W       = 15;
  localparam int RATIO_W     = 13;
  localparam int KNEE_W      = 12;
  localparam int CFG_W       = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int M_W         = 31;
  localparam int FR_W        = 16;
  localparam int SQ_N        = 16;
  localparam int L_W         = E_W + FR_W;
  localparam int MUL_W       = L_W + 20;
  localparam int G_W         = 41;
  localparam int T_W         = 28;
  localparam int S_W         = 24;
  localparam int SQR_W       = 2 * S_W;
  localparam int W_W         = 23;
  localparam int WR_W        = 36;
  localparam int DEN_W       = 47;
  localparam int NUM_W       = 62;
  localparam int Q_W         = 15;
  localparam int EXP_LAT     = SQ_N + 3;

  localparam int DB_PER_LOG2 = 394566;
  localparam int LOG2_PER_DB = 2786635;
  localparam int ZERO_DB     = -40960;
  localparam int KNEE_STEP   = 1536;
  localparam int KNEE_BASE   = 3932;
  localparam int RATIO_MIN   = 256;
  localparam int RATIO_RST   = 768;
  localparam int KNEE_RST    = 768;
  localparam int W_RST       = KNEE_RST * KNEE_STEP + KNEE_BASE;
  localparam int WR_RST      = W_RST * RATIO_RST;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_RATIO     = 2'd1,
    CFG_KNEE      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BR_BELOW,
    BR_KNEE,
    BR_ABOVE
  } branch_e;

  typedef struct packed {
    logic adv;
    logic vld;
  } skcc_ctl_t;

  typedef logic [SQ_N:0][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 64'd0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // c[k] = 2^(2^-k) in Q2.30
  function automatic root_tab_t make_roots();
    root_tab_t c;
    c[0] = 32'h8000_0000;
    for (int k = 1; k <= SQ_N; k++) begin
      c[k] = 32'(isqrt64({c[k-1], 30'b0}));
    end
    return c;
  endfunction

  localparam root_tab_t ROOTS = make_roots();

endpackage

// ===== sv/skcc_log.sv =====
`timescale 1ns / 1ps

module skcc_log (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skcc_pkg::skcc_ctl_t                 ctl_i,
  input  logic [skcc_pkg::LEVEL_BITS-1:0]     level_i,
  output logic                                vld_o,
  output logic signed [skcc_pkg::DB_W-1:0]    db_o
);
  import skcc_pkg::*;

  localparam int WIDE_W = LEVEL_BITS + M_W;
  localparam logic signed [19:0] DB_K = 20'sd394566;
  localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(64'sd8388608);

  logic [P_W-1:0]             p;
  logic [WIDE_W-1:0]          wide;
  logic                       n_v_q;
  logic [M_W-1:0]             n_m_d, n_m_q;
  logic signed [E_W-1:0]      n_e_d, n_e_q;
  logic                       n_z_q;

  logic                       sq_v_q [SQ_N];
  logic [M_W-1:0]             sq_m_d [SQ_N];
  logic [M_W-1:0]             sq_m_q [SQ_N];
  logic [FR_W-1:0]            sq_f_d [SQ_N];
  logic [FR_W-1:0]            sq_f_q [SQ_N];
  logic signed [E_W-1:0]      sq_e_q [SQ_N];
  logic                       sq_z_q [SQ_N];
  logic [M_W-1:0]             src_m  [SQ_N];
  logic [FR_W-1:0]            src_f  [SQ_N];
  logic [2*M_W-1:0]           prod   [SQ_N];
  logic [M_W:0]               mm     [SQ_N];

  logic signed [L_W-1:0]      l_val;
  logic                       mul_v_q;
  logic signed [MUL_W-1:0]    mul_d, mul_q;
  logic                       mul_z_q;
  logic signed [MUL_W-1:0]    rnd_sum;
  logic                       out_v_q;
  logic signed [DB_W-1:0]     db_d, db_q;

  // normalize to Q1.30
  always_comb begin
    p = '0;
    for (int k = 0; k < LEVEL_BITS; k++) begin
      if (level_i[k]) p = P_W'(k);
    end
    wide  = {level_i, {M_W{1'b0}}} >> ({1'b0, p} + 1'b1);
    n_m_d = wide[M_W-1:0];
    n_e_d = E_W'(p) - E_W'(FRAC_BITS);
  end

  // one log2 fraction bit per squaring
  always_comb begin
    for (int j = 0; j < SQ_N; j++) begin
      src_m[j]  = (j == 0) ? n_m_q : sq_m_q[(j == 0) ? 0 : j - 1];
      src_f[j]  = (j == 0) ? '0    : sq_f_q[(j == 0) ? 0 : j - 1];
      prod[j]   = (2*M_W)'(src_m[j]) * (2*M_W)'(src_m[j]);
      mm[j]     = prod[j][2*M_W-1:M_W-1];
      sq_m_d[j] = mm[j][M_W] ? mm[j][M_W:1] : mm[j][M_W-1:0];
      sq_f_d[j] = {src_f[j][FR_W-2:0], mm[j][M_W]};
    end
  end

  always_comb begin
    l_val   = {sq_e_q[SQ_N-1], sq_f_q[SQ_N-1]};
    mul_d   = l_val * DB_K;
    rnd_sum = mul_q + RND_HALF;
    db_d    = mul_z_q ? DB_W'(ZERO_DB) : rnd_sum[DB_W+23:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q   <= 1'b0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j < SQ_N; j++) sq_v_q[j] <= 1'b0;
    end else if (ctl_i.adv) begin
      n_v_q     <= ctl_i.vld;
      sq_v_q[0] <= n_v_q;
      for (int j = 1; j < SQ_N; j++) sq_v_q[j] <= sq_v_q[j-1];
      mul_v_q   <= sq_v_q[SQ_N-1];
      out_v_q   <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      n_m_q     <= n_m_d;
      n_e_q     <= n_e_d;
      n_z_q     <= (level_i == '0);
      sq_e_q[0] <= n_e_q;
      sq_z_q[0] <= n_z_q;
      for (int j = 0; j < SQ_N; j++) begin
        sq_m_q[j] <= sq_m_d[j];
        sq_f_q[j] <= sq_f_d[j];
      end
      for (int j = 1; j < SQ_N; j++) begin
        sq_e_q[j] <= sq_e_q[j-1];
        sq_z_q[j] <= sq_z_q[j-1];
      end
      mul_q   <= mul_d;
      mul_z_q <= sq_z_q[SQ_N-1];
      db_q    <= db_d;
    end
  end

  assign vld_o = out_v_q;
  assign db_o  = db_q;

endmodule

// ===== sv/skcc_exp.sv =====
`timescale 1ns / 1ps

module skcc_exp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skcc_pkg::skcc_ctl_t                 ctl_i,
  input  logic signed [skcc_pkg::Y_W-1:0]     y_i,
  output logic                                vld_o,
  output logic [skcc_pkg::LEVEL_BITS-1:0]     level_o
);
  import skcc_pkg::*;

  localparam logic signed [22:0]    EXP_K = 23'sd2786635;
  localparam logic signed [G_W-1:0] G_OFF = 41'sh40_0000_0000;
  localparam logic [M_W-1:0]        M_ONE = 31'h4000_0000;
  localparam logic [63:0]           L_MAX = 64'({LEVEL_BITS{1'b1}});

  logic signed [G_W-1:0] g;
  logic                  g_v_q;
  logic [6:0]            g_n_q;
  logic [FR_W-1:0]       g_f_q;

  logic                  mp_v_q [SQ_N];
  logic [M_W-1:0]        mp_m_d [SQ_N];
  logic [M_W-1:0]        mp_m_q [SQ_N];
  logic [6:0]            mp_n_q [SQ_N];
  logic [FR_W-1:0]       mp_f_q [SQ_N];
  logic [M_W-1:0]        src_m  [SQ_N];
  logic [FR_W-1:0]       src_f  [SQ_N];
  logic [2*M_W-1:0]      prod   [SQ_N];

  logic signed [7:0]     ex;
  logic [6:0]            sh;
  logic [63:0]           sc_d, sc_q;
  logic                  sat_d, sat_q;
  logic                  sc_v_q;
  logic                  out_v_q;
  logic [LEVEL_BITS-1:0] lvl_d, lvl_q;

  assign g = y_i * EXP_K + G_OFF;

  always_comb begin
    for (int j = 0; j < SQ_N; j++) begin
      src_m[j]  = (j == 0) ? M_ONE : mp_m_q[(j == 0) ? 0 : j - 1];
      src_f[j]  = (j == 0) ? g_f_q : mp_f_q[(j == 0) ? 0 : j - 1];
      prod[j]   = (2*M_W)'(src_m[j]) * (2*M_W)'(ROOTS[j+1][M_W-1:0]);
      mp_m_d[j] = src_f[j][FR_W-1-j] ? prod[j][2*M_W-2:M_W-1] : src_m[j];
    end
  end

  // exponent: n - 10, n = (G >> 32) - 64
  always_comb begin
    ex    = $signed({1'b0, mp_n_q[SQ_N-1]}) - 8'sd74;
    sh    = 7'(-ex);
    sc_d  = '0;
    sat_d = 1'b0;
    if (!ex[7]) begin
      sat_d = (ex > 8'sd32);
      sc_d  = 64'(mp_m_q[SQ_N-1]) << ex[5:0];
    end else if (sh <= 7'd40) begin
      sc_d = (64'(mp_m_q[SQ_N-1]) + (64'd1 << (sh - 7'd1))) >> sh;
    end
    lvl_d = (sat_q || (sc_q > L_MAX)) ? {LEVEL_BITS{1'b1}} : sc_q[LEVEL_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q   <= 1'b0;
      sc_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j < SQ_N; j++) mp_v_q[j] <= 1'b0;
    end else if (ctl_i.adv) begin
      g_v_q     <= ctl_i.vld;
      mp_v_q[0] <= g_v_q;
      for (int j = 1; j < SQ_N; j++) mp_v_q[j] <= mp_v_q[j-1];
      sc_v_q    <= mp_v_q[SQ_N-1];
      out_v_q   <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      g_n_q     <= g[38:32];
      g_f_q     <= g[31:16];
      mp_n_q[0] <= g_n_q;
      mp_f_q[0] <= g_f_q;
      for (int j = 0; j < SQ_N; j++) mp_m_q[j] <= mp_m_d[j];
      for (int j = 1; j < SQ_N; j++) begin
        mp_n_q[j] <= mp_n_q[j-1];
        mp_f_q[j] <= mp_f_q[j-1];
      end
      sc_q  <= sc_d;
      sat_q <= sat_d;
      lvl_q <= lvl_d;
    end
  end

  assign vld_o   = out_v_q;
  assign level_o = lvl_q;

endmodule

// ===== sv/soft_knee_compressor_curve.sv =====
`timescale 1ns / 1ps

// Soft-knee compressor static curve.
// Input channel: level_i with in_valid_i / in_stall_o. Output channel:
// in_db_o, out_db_o, out_level_o, in_level_o with out_valid_o / out_stall_i.
// A transfer happens on a rising edge with valid high and stall low.
// Throughput: one item per cycle while in_stall_o is low. The path from input
// transfer to out_valid_o runs through the log2 squaring chain, the knee curve
// and its 15-step restoring divider, the two exp2 multiply chains and the
// output register.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 threshold, 1 ratio, 2 knee); write only while the block is empty.
// Reset clears all valid bits and loads threshold 0 dB, ratio 3, knee 3.
// When the receiver stalls, a two-entry output queue keeps taking results;
// once its second entry fills, in_stall_o rises and the whole pipeline
// holds until the head result is taken. No result is lost or repeated.
module soft_knee_compressor_curve (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [skcc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [skcc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [skcc_pkg::LEVEL_BITS-1:0]     level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [skcc_pkg::DB_W-1:0]    in_db_o,
  output logic signed [skcc_pkg::DB_W-1:0]    out_db_o,
  output logic [skcc_pkg::LEVEL_BITS-1:0]     out_level_o,
  output logic [skcc_pkg::LEVEL_BITS-1:0]     in_level_o
);
  import skcc_pkg::*;

  // configuration
  logic [THR_W-1:0]        thr_q;
  logic [RATIO_W-1:0]      ratio_q;
  logic [KNEE_W-1:0]       knee_q;
  logic signed [THR_W-1:0] thr;
  logic [RATIO_W-1:0]      r_eff;
  logic [W_W-1:0]          w_d, w_q;
  logic [WR_W-1:0]         wr_q;
  logic [DEN_W-1:0]        den_knee;

  // flow control
  logic                    en;
  skcc_ctl_t               log_ctl;
  skcc_ctl_t               exp_ctl;

  // log2 -> dB
  logic                    lg_v;
  logic signed [DB_W-1:0]  lg_db;

  // curve
  logic signed [Y_W-1:0]   d;
  logic signed [T_W-1:0]   t, wt, ts;
  branch_e                 br_d;
  logic                    c0_v_q;
  logic signed [DB_W-1:0]  c0_xg_q;
  logic signed [Y_W-1:0]   c0_d_q;
  logic [S_W-1:0]          c0_s_q;
  branch_e                 c0_br_q;
  logic                    c1_v_q;
  logic signed [DB_W-1:0]  c1_xg_q;
  logic signed [Y_W-1:0]   c1_d_q;
  logic [SQR_W-1:0]        c1_sq_q;
  branch_e                 c1_br_q;
  logic [NUM_W-1:0]        num_d;
  logic [DEN_W-1:0]        den_d;

  // divider
  logic                    dv_v_q   [Q_W+1];
  logic [NUM_W-1:0]        dv_rem_q [Q_W+1];
  logic [DEN_W-1:0]        dv_den_q [Q_W+1];
  logic [Q_W-1:0]          dv_q_q   [Q_W+1];
  logic signed [DB_W-1:0]  dv_xg_q  [Q_W+1];
  branch_e                 dv_br_q  [Q_W+1];
  logic [NUM_W-1:0]        dv_sub   [Q_W];
  logic                    dv_ge    [Q_W];
  logic [NUM_W-1:0]        dv_rem_d [Q_W];
  logic [Q_W-1:0]          dv_q_d   [Q_W];

  // result dB
  logic signed [Y_W-1:0]   yg_d;
  logic                    py_v_q;
  logic signed [Y_W-1:0]   py_yg_q;
  logic signed [DB_W-1:0]  py_xg_q;
  logic signed [DB_W-1:0]  dl_xg_q [EXP_LAT];
  logic signed [Y_W-1:0]   dl_yg_q [EXP_LAT];

  // dB -> linear
  logic                    ex_out_v;
  logic                    ex_in_v;
  logic [LEVEL_BITS-1:0]   ex_out_lvl;
  logic [LEVEL_BITS-1:0]   ex_in_lvl;

  // output queue
  logic                    tail_v;
  logic                    push;
  logic                    pop;
  logic                    ov_q, sv_q;
  logic signed [DB_W-1:0]  o_in_db_q, o_out_db_q, s_in_db_q, s_out_db_q;
  logic [LEVEL_BITS-1:0]   o_out_lvl_q, o_in_lvl_q, s_out_lvl_q, s_in_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      ratio_q <= RATIO_W'(RATIO_RST);
      knee_q  <= KNEE_W'(KNEE_RST);
      w_q     <= W_W'(W_RST);
      wr_q    <= WR_W'(WR_RST);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
          CFG_RATIO:     ratio_q <= cfg_data_i[RATIO_W-1:0];
          CFG_KNEE:      knee_q  <= cfg_data_i[KNEE_W-1:0];
          default: ;
        endcase
      end
      w_q  <= w_d;
      wr_q <= WR_W'(w_q) * WR_W'(r_eff);
    end
  end

  assign thr      = $signed(thr_q);
  assign r_eff    = (ratio_q < RATIO_W'(RATIO_MIN)) ? RATIO_W'(RATIO_MIN) : ratio_q;
  assign w_d      = W_W'(knee_q) * W_W'(KNEE_STEP) + W_W'(KNEE_BASE);
  assign den_knee = {wr_q, 11'b0};

  assign en          = !sv_q;
  assign in_stall_o  = sv_q;
  assign log_ctl.adv = en;
  assign log_ctl.vld = in_valid_i;

  skcc_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (log_ctl),
    .level_i (level_i),
    .vld_o   (lg_v),
    .db_o    (lg_db)
  );

  // region select
  always_comb begin
    d  = Y_W'(lg_db) - Y_W'(thr);
    t  = T_W'(d) <<< 9;
    wt = T_W'($signed({1'b0, w_q}));
    ts = t + wt;
    if (t < -wt) begin
      br_d = BR_BELOW;
    end else if (t <= wt) begin
      br_d = BR_KNEE;
    end else begin
      br_d = BR_ABOVE;
    end
  end

  // dividend and divisor for the active region
  always_comb begin
    num_d = '0;
    den_d = DEN_W'(r_eff);
    case (c1_br_q)
      BR_KNEE: begin
        num_d = NUM_W'(c1_sq_q) * NUM_W'(r_eff - RATIO_W'(RATIO_MIN))
              + NUM_W'({wr_q, 10'b0});
        den_d = den_knee;
      end
      BR_ABOVE: begin
        num_d = NUM_W'({c1_d_q[Y_W-2:0], 8'b0}) + NUM_W'(r_eff >> 1);
      end
      default: ;
    endcase
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      dv_sub[j]   = NUM_W'(dv_den_q[j]) << (Q_W - 1 - j);
      dv_ge[j]    = (dv_rem_q[j] >= dv_sub[j]);
      dv_rem_d[j] = dv_ge[j] ? (dv_rem_q[j] - dv_sub[j]) : dv_rem_q[j];
      dv_q_d[j]   = dv_q_q[j] | (dv_ge[j] ? (Q_W'(1) << (Q_W - 1 - j)) : '0);
    end
  end

  always_comb begin
    case (dv_br_q[Q_W])
      BR_KNEE:  yg_d = Y_W'(dv_xg_q[Q_W]) - $signed(Y_W'(dv_q_q[Q_W]));
      BR_ABOVE: yg_d = Y_W'(thr) + $signed(Y_W'(dv_q_q[Q_W]));
      default:  yg_d = Y_W'(dv_xg_q[Q_W]);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_v_q <= 1'b0;
      c1_v_q <= 1'b0;
      py_v_q <= 1'b0;
      for (int j = 0; j <= Q_W; j++) dv_v_q[j] <= 1'b0;
    end else if (en) begin
      c0_v_q    <= lg_v;
      c1_v_q    <= c0_v_q;
      dv_v_q[0] <= c1_v_q;
      for (int j = 0; j < Q_W; j++) dv_v_q[j+1] <= dv_v_q[j];
      py_v_q    <= dv_v_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_xg_q     <= lg_db;
      c0_d_q      <= d;
      c0_s_q      <= ts[S_W-1:0];
      c0_br_q     <= br_d;
      c1_xg_q     <= c0_xg_q;
      c1_d_q      <= c0_d_q;
      c1_sq_q     <= SQR_W'(c0_s_q) * SQR_W'(c0_s_q);
      c1_br_q     <= c0_br_q;
      dv_rem_q[0] <= num_d;
      dv_den_q[0] <= den_d;
      dv_q_q[0]   <= '0;
      dv_xg_q[0]  <= c1_xg_q;
      dv_br_q[0]  <= c1_br_q;
      for (int j = 0; j < Q_W; j++) begin
        dv_rem_q[j+1] <= dv_rem_d[j];
        dv_den_q[j+1] <= dv_den_q[j];
        dv_q_q[j+1]   <= dv_q_d[j];
        dv_xg_q[j+1]  <= dv_xg_q[j];
        dv_br_q[j+1]  <= dv_br_q[j];
      end
      py_yg_q    <= yg_d;
      py_xg_q    <= dv_xg_q[Q_W];
      dl_xg_q[0] <= py_xg_q;
      dl_yg_q[0] <= py_yg_q;
      for (int j = 1; j < EXP_LAT; j++) begin
        dl_xg_q[j] <= dl_xg_q[j-1];
        dl_yg_q[j] <= dl_yg_q[j-1];
      end
    end
  end

  assign exp_ctl.adv = en;
  assign exp_ctl.vld = py_v_q;

  skcc_exp u_exp_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (exp_ctl),
    .y_i     (py_yg_q),
    .vld_o   (ex_out_v),
    .level_o (ex_out_lvl)
  );

  skcc_exp u_exp_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (exp_ctl),
    .y_i     (Y_W'(py_xg_q)),
    .vld_o   (ex_in_v),
    .level_o (ex_in_lvl)
  );

  assign tail_v = ex_out_v && ex_in_v;
  assign push   = en && tail_v;
  assign pop    = ov_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || pop) begin
      ov_q <= sv_q || push;
      sv_q <= sv_q && push;
    end else if (push) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || pop) begin
      if (sv_q) begin
        o_in_db_q   <= s_in_db_q;
        o_out_db_q  <= s_out_db_q;
        o_out_lvl_q <= s_out_lvl_q;
        o_in_lvl_q  <= s_in_lvl_q;
      end else begin
        o_in_db_q   <= dl_xg_q[EXP_LAT-1];
        o_out_db_q  <= dl_yg_q[EXP_LAT-1][DB_W-1:0];
        o_out_lvl_q <= ex_out_lvl;
        o_in_lvl_q  <= ex_in_lvl;
      end
    end
    if (push) begin
      s_in_db_q   <= dl_xg_q[EXP_LAT-1];
      s_out_db_q  <= dl_yg_q[EXP_LAT-1][DB_W-1:0];
      s_out_lvl_q <= ex_out_lvl;
      s_in_lvl_q  <= ex_in_lvl;
    end
  end

  assign out_valid_o = ov_q;
  assign in_db_o     = o_in_db_q;
  assign out_db_o    = o_out_db_q;
  assign out_level_o = o_out_lvl_q;
  assign in_level_o  = o_in_lvl_q;

`ifndef ASSERT_OFF
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("second queue entry held without a head entry");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> ov_q)
    else $error("finished result did not reach the output");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[Q_W] |-> (dv_rem_q[Q_W] < NUM_W'(dv_den_q[Q_W])))
    else $error("divider remainder not below divisor");
`endif

endmodule
